// ----- src/spcr_pkg.sv -----
// ----------------------------------------------------------------------------
// spcr_pkg
// Shared types, codes and helper functions of the serial port control block.
// ----------------------------------------------------------------------------
package spcr_pkg;

  localparam int unsigned CtlW  = 16;
  localparam int unsigned CntW  = 14;
  localparam int unsigned CycW  = 20;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned DevW  = 3;
  localparam int unsigned PlyrW = 2;
  localparam int unsigned ModeW = 3;

  localparam logic [CmdW-1:0] CmdWriteMode = 2'd0;
  localparam logic [CmdW-1:0] CmdWriteCtl  = 2'd1;
  localparam logic [CmdW-1:0] CmdTick      = 2'd2;
  localparam logic [CmdW-1:0] CmdNop       = 2'd3;

  localparam logic [ModeW-1:0] ModeNormal = 3'd0;
  localparam logic [ModeW-1:0] ModeMulti  = 3'd1;
  localparam logic [ModeW-1:0] ModeUart   = 3'd2;
  localparam logic [ModeW-1:0] ModeGpio   = 3'd3;
  localparam logic [ModeW-1:0] ModeJoybus = 3'd4;

  localparam logic [DevW-1:0] DevNone   = 3'd0;
  localparam logic [DevW-1:0] DevRfu    = 3'd1;
  localparam logic [DevW-1:0] DevRumble = 3'd2;
  localparam logic [DevW-1:0] DevLink   = 3'd3;

  localparam logic [0:0] CfgDevice = 1'b0;
  localparam logic [0:0] CfgPlayer = 1'b1;

  localparam logic [CntW-1:0] CycFast   = 14'd67;
  localparam logic [CntW-1:0] CycSlow   = 14'd524;
  localparam logic [CntW-1:0] CycRumble = 14'd8192;

  localparam logic [CtlW-1:0] MaskNormal = 16'h7FFB;
  localparam logic [CtlW-1:0] MaskMulti  = 16'h7F83;
  localparam logic [CtlW-1:0] MaskUart   = 16'h7F8F;
  localparam logic [CtlW-1:0] MaskGpio   = 16'h7000;
  localparam logic [CtlW-1:0] MultiBits  = 16'h007C;

  typedef struct packed {
    logic [CtlW-1:0] ctl;
    logic [CtlW-1:0] mode;
    logic [CntW-1:0] cnt;
  } state_t;

  typedef struct packed {
    logic [CtlW-1:0] ctl;
    logic [CtlW-1:0] mode;
    logic            irq;
    logic [CntW-1:0] cnt;
    logic            dev_reset;
    logic            lnk;
  } result_t;

  function automatic logic [ModeW-1:0] decode_mode(logic [CtlW-1:0] ctl,
                                                   logic [CtlW-1:0] md);
    logic [ModeW-1:0] m;
    begin
      if (md[15]) begin
        m = md[14] ? ModeJoybus : ModeGpio;
      end else if (ctl[13]) begin
        m = ctl[12] ? ModeUart : ModeMulti;
      end else begin
        m = ModeNormal;
      end
      return m;
    end
  endfunction

  function automatic logic [CtlW-1:0] enter_mode(logic [ModeW-1:0] m,
                                                 logic [CtlW-1:0] ctl,
                                                 logic [PlyrW-1:0] pn);
    logic [CtlW-1:0] r;
    begin
      r = ctl;
      if (m == ModeNormal) begin
        r[2] = 1'b0;
      end else if (m == ModeMulti) begin
        r      = ctl & ~MultiBits;
        r[2]   = (pn != '0);
        r[5:4] = pn;
        r[3]   = 1'b1;
      end
      return r;
    end
  endfunction

  function automatic logic [CtlW-1:0] write_mask(logic [ModeW-1:0] m);
    logic [CtlW-1:0] mk;
    begin
      unique case (m)
        ModeNormal: mk = MaskNormal;
        ModeMulti:  mk = MaskMulti;
        ModeUart:   mk = MaskUart;
        default:    mk = MaskGpio;
      endcase
      return mk;
    end
  endfunction

  function automatic logic [CntW-1:0] short_transfer(logic [CtlW-1:0] v);
    logic [CntW-1:0] c;
    begin
      c = v[1] ? CycFast : CycSlow;
      if (v[12]) begin
        c = {c[CntW-3:0], 2'b00};
      end
      return c;
    end
  endfunction

endpackage

// ----- src/serial_port_control_registers.sv -----
// ----------------------------------------------------------------------------
// serial_port_control_registers
// Serial port control and mode registers with mode-masked writes, adapter
// handshake emulation and a transfer countdown with completion interrupt.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid_i / in_ready_o   | command, write_value, elapsed_cycles
//  out     | output    | out_valid_o / out_ready_i | control/mode value, flags, countdown
//  cfg     | input     | cfg_we_i                  | cfg_addr_i, cfg_data_i
//
//  One request per cycle sustained while out_ready_i stays high.
//  The request register feeds the update logic, which writes the state and the
//  result register in the same cycle.
//  Reset clears the control, mode and countdown state and the device settings.
//  A stalled result holds the request register; input stalls only when both are full.
// ----------------------------------------------------------------------------
module serial_port_control_registers (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [spcr_pkg::CmdW-1:0]   command_i,
  input  logic [spcr_pkg::CtlW-1:0]   write_value_i,
  input  logic [spcr_pkg::CycW-1:0]   elapsed_cycles_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [spcr_pkg::CtlW-1:0]   control_value_o,
  output logic [spcr_pkg::CtlW-1:0]   mode_value_o,
  output logic                        irq_raised_o,
  output logic [spcr_pkg::CntW-1:0]   cycles_to_event_o,
  output logic                        device_reset_o,
  output logic                        link_start_o,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_addr_i,
  input  logic [spcr_pkg::DevW-1:0]   cfg_data_i
);
  import spcr_pkg::*;

  logic              req_valid_q;
  logic [CmdW-1:0]   cmd_q;
  logic [CtlW-1:0]   val_q;
  logic [CycW-1:0]   cyc_q;
  logic              out_valid_q;
  result_t           res_q;
  result_t           res_d;
  state_t            state_q;
  state_t            state_d;
  logic [DevW-1:0]   dev_q;
  logic [PlyrW-1:0]  plyr_q;
  logic              in_fire;
  logic              req_fire;

  assign req_fire   = req_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || req_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  spcr_core u_core (
    .cmd_i   (cmd_q),
    .val_i   (val_q),
    .cyc_i   (cyc_q),
    .dev_i   (dev_q),
    .plyr_i  (plyr_q),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q  <= DevNone;
      plyr_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgDevice: dev_q  <= cfg_data_i;
        CfgPlayer: plyr_q <= cfg_data_i[PlyrW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_fire) begin
        req_valid_q <= 1'b1;
      end else if (req_fire) begin
        req_valid_q <= 1'b0;
      end
      if (req_fire) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= command_i;
      val_q <= write_value_i;
      cyc_q <= elapsed_cycles_i;
    end
    if (req_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign control_value_o   = res_q.ctl;
  assign mode_value_o      = res_q.mode;
  assign irq_raised_o      = res_q.irq;
  assign cycles_to_event_o = res_q.cnt;
  assign device_reset_o    = res_q.dev_reset;
  assign link_start_o      = res_q.lnk;

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.cnt <= CycRumble)
    else $error("countdown out of range");

  a_no_irq_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && cmd_q == CmdTick && state_q.cnt == '0) |=> !irq_raised_o)
    else $error("interrupt without pending transfer");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (req_valid_q && out_valid_q))
    else $error("input stalled with free stage");

  a_result_after_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (out_valid_q && state_q.cnt == res_q.cnt))
    else $error("result register not loaded");
`endif

endmodule

// ----- src/spcr_core.sv -----
// ----------------------------------------------------------------------------
// spcr_core
// Next-state and result logic for one request: mode and control writes with
// mode masking, adapter handshake emulation, transfer start and tick countdown.
// ----------------------------------------------------------------------------
module spcr_core (
  input  logic [spcr_pkg::CmdW-1:0]  cmd_i,
  input  logic [spcr_pkg::CtlW-1:0]  val_i,
  input  logic [spcr_pkg::CycW-1:0]  cyc_i,
  input  logic [spcr_pkg::DevW-1:0]  dev_i,
  input  logic [spcr_pkg::PlyrW-1:0] plyr_i,
  input  spcr_pkg::state_t           state_i,
  output spcr_pkg::state_t           state_o,
  output spcr_pkg::result_t          res_o
);
  import spcr_pkg::*;

  logic [ModeW-1:0] om;
  logic [ModeW-1:0] nm;
  logic [CtlW-1:0]  mk;
  logic [CtlW-1:0]  nv;
  logic             start;
  logic             internal;
  logic             idle;
  logic             irq;
  logic             dev_reset;
  logic             lnk;
  state_t           nxt;

  always_comb begin
    nxt       = state_i;
    irq       = 1'b0;
    dev_reset = 1'b0;
    lnk       = 1'b0;
    om        = decode_mode(state_i.ctl, state_i.mode);
    nm        = om;
    mk        = write_mask(om);
    nv        = state_i.ctl;
    start     = 1'b0;
    internal  = 1'b0;
    idle      = (state_i.cnt == '0);
    unique case (cmd_i)
      CmdWriteMode: begin
        nm       = decode_mode(state_i.ctl, val_i);
        nxt.mode = val_i;
        if (om != nm) begin
          nxt.ctl = enter_mode(nm, state_i.ctl, plyr_i);
        end
        dev_reset = (nm == ModeGpio) && (dev_i == DevRfu) && val_i[5] && !state_i.mode[1];
      end
      CmdWriteCtl: begin
        nm       = decode_mode(val_i, state_i.mode);
        mk       = write_mask(nm);
        nv       = (val_i & mk) | (state_i.ctl & ~mk);
        start    = nv[7];
        internal = nv[0];
        if (nm == ModeNormal) begin
          if (dev_i == DevRfu) begin
            if (start && internal && idle) begin
              nxt.cnt = short_transfer(nv);
              nv[2]   = 1'b1;
            end
            if (internal) begin
              if (nv[3] && !state_i.ctl[3]) begin
                nv[2] = 1'b0;
              end
            end else begin
              if (nv[3] && !state_i.ctl[3]) begin
                nv[2] = 1'b1;
              end
              if (!nv[3] && state_i.ctl[3]) begin
                nv[2] = 1'b0;
              end
            end
          end else if (dev_i == DevRumble) begin
            if (start && !internal && idle) begin
              nxt.cnt = CycRumble;
            end
          end else if (dev_i == DevNone) begin
            if (start && !internal && idle) begin
              nxt.cnt = short_transfer(nv);
            end
          end
        end else if (nm == ModeMulti) begin
          lnk = (dev_i == DevLink) && start && !nv[2] && idle;
        end
        nxt.ctl = (om != nm) ? enter_mode(nm, nv, plyr_i) : nv;
      end
      CmdTick: begin
        if (!idle) begin
          if ({{(CycW-CntW){1'b0}}, state_i.cnt} > cyc_i) begin
            nxt.cnt = state_i.cnt - cyc_i[CntW-1:0];
          end else begin
            nxt.cnt    = '0;
            nxt.ctl[7] = 1'b0;
            irq        = state_i.ctl[14];
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign state_o         = nxt;
  assign res_o.ctl       = nxt.ctl;
  assign res_o.mode      = nxt.mode;
  assign res_o.irq       = irq;
  assign res_o.cnt       = nxt.cnt;
  assign res_o.dev_reset = dev_reset;
  assign res_o.lnk       = lnk;

endmodule
